// ----- rtl/pbrt_pkg.sv -----
// Package of the piece block request tracker: codes, state names and
// shared record types. Depends on nothing.
package pbrt_pkg;

   localparam int unsigned BLOCK_BYTES = 16384;
   localparam int unsigned BLOCK_SHIFT = 14;
   localparam int unsigned RCV_MAX     = 511;
   localparam int unsigned RCV_W       = 9;

   typedef enum logic [2:0] {
      K_NEXT     = 3'd0,
      K_RECEIVED = 3'd1,
      K_REQ_FAIL = 3'd2,
      K_COMPLETE = 3'd3,
      K_FAILED   = 3'd4,
      K_QUERY    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BS_PENDING   = 2'd0,
      BS_REQUESTED = 2'd1,
      BS_RECEIVED  = 2'd2
   } blk_state_type;

   typedef enum logic [1:0] {
      CSR_PIECE_SIZE = 2'd0,
      CSR_FILE_SIZE  = 2'd1,
      CSR_PIECE_CNT  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLR,
      S_IDLE,
      S_LEN,
      S_EXEC,
      S_WIPE,
      S_SCAN,
      S_SCHK,
      S_MATCH,
      S_MCHK,
      S_DONE
   } seq_state_type;

   // request to the piece length unit
   typedef struct packed {
      logic        start;
      logic [11:0] idx;
      logic        last;
   } len_req_type;

   // one result item
   typedef struct packed {
      status_type  status;
      logic        found;
      logic [21:0] boff;
      logic [14:0] blen;
      logic        full;
      logic        pend;
      logic        have;
   } res_type;

endpackage

// ----- rtl/pbrt_if.sv -----
// Handshake channel interfaces of the piece block request tracker:
// request, response and register write channels. No dependencies.
interface pbrt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [11:0] piece_index;
   logic [21:0] block_offset_in;
   logic [22:0] payload_bytes;
   modport source (output valid, kind, piece_index, block_offset_in, payload_bytes,
                   input ready);
   modport sink   (input valid, kind, piece_index, block_offset_in, payload_bytes,
                   output ready);
endinterface

interface pbrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        block_found;
   logic [21:0] block_offset_out;
   logic [14:0] block_length;
   logic        piece_full;
   logic        pending_left;
   logic        have_piece;
   modport source (output valid, status, block_found, block_offset_out, block_length,
                   piece_full, pending_left, have_piece, input ready);
   modport sink   (input valid, status, block_found, block_offset_out, block_length,
                   piece_full, pending_left, have_piece, output ready);
endinterface

interface pbrt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [34:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pbrt_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module pbrt_ram #(
   parameter int W  = 2,
   parameter int AW = 11
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);
   logic [W-1:0] mem_ff [2**AW];
   logic [W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/pbrt_len_unit.sv -----
// Piece length unit: two-stage multiply and saturate giving a piece's
// byte length. Depends on pbrt_pkg.
module pbrt_len_unit #(
   parameter int MAX_BLOCKS = 256,
   parameter int LEN_W      = 23
) (
   input  logic               clock,
   input  logic               reset,
   input  pbrt_pkg::len_req_type req,
   input  logic [22:0]        piece_size,
   input  logic [34:0]        file_size,
   output logic [LEN_W-1:0]   len,
   output logic               done
);
   localparam longint unsigned CAP = longint'(MAX_BLOCKS) * pbrt_pkg::BLOCK_BYTES;

   logic [34:0]      prod_ff;
   logic             last_ff;
   logic             stg1_ff;
   logic             done_ff;
   logic [LEN_W-1:0] len_ff;
   logic [34:0]      raw;

   // stage 1: bytes before the piece, when it is the last one
   always_ff @(posedge clock) begin
      if (req.start) begin
         prod_ff <= 35'(req.idx) * 35'(piece_size);
         last_ff <= req.last;
      end
   end

   // stage 2: remaining length for the last piece, else the piece size, saturated to the cap
   always_comb begin
      if (last_ff) begin
         raw = (file_size > prod_ff) ? file_size - prod_ff : 35'd0;
      end else begin
         raw = 35'(piece_size);
      end
   end

   // length held until the next request
   always_ff @(posedge clock) begin
      if (stg1_ff) begin
         len_ff <= (raw > 35'(CAP)) ? LEN_W'(CAP) : LEN_W'(raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg1_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stg1_ff <= req.start;
         done_ff <= stg1_ff;
      end
   end

   assign len  = len_ff;
   assign done = done_ff;
endmodule

// ----- rtl/piece_block_request_tracker.sv -----
// Top level of the piece block request tracker: sequencer, slot table and
// CSRs. Depends on pbrt_pkg, pbrt_if, pbrt_ram and pbrt_len_unit.
//
// One request item is taken at a time and yields one response item. After
// reset the completed-piece bitmap is cleared in a pass over its MAX_PIECES
// entries during which no request is accepted (register writes are). A plain
// item passes from acceptance to the next possible acceptance through the
// accept cycle, which also starts the bitmap read, the piece length unit, decode
// and the response stage. Opening a slot first resets its block states;
// received and request-failed items add the block match; a next-block or
// pending query scans the block state RAM block by block up to the first
// pending one. A fresh slot's first block is pending, so the worst case is a
// scan through every block of an open slot. A response not yet taken holds
// the item in the response stage. Register writes are accepted every cycle.
module piece_block_request_tracker #(
   parameter int MAX_PIECES = 4096,
   parameter int SLOTS      = 8,
   parameter int MAX_BLOCKS = 256
) (
   input  logic clock,
   input  logic reset,
   pbrt_req_if.sink   req_ch,
   pbrt_rsp_if.source rsp_ch,
   pbrt_csr_if.sink   csr_ch
);
   localparam int BM_AW   = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int LEN_W   = $clog2(MAX_BLOCKS * 16384 + 1);
   localparam int SW      = LEN_W + 1;
   localparam int CMP_W   = 26;
   localparam int BA_W    = SLOT_W + BLK_W;

   // configuration registers
   logic [22:0] psize_ff;
   logic [34:0] fsize_ff;
   logic [12:0] pcount_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff  <= 23'd262144;
         fsize_ff  <= 35'd0;
         pcount_ff <= 13'd0;
      end else if (csr_ch.valid) begin
         case (pbrt_pkg::csr_index_type'(csr_ch.index))
            pbrt_pkg::CSR_PIECE_SIZE: psize_ff  <= csr_ch.data[22:0];
            pbrt_pkg::CSR_FILE_SIZE:  fsize_ff  <= csr_ch.data;
            pbrt_pkg::CSR_PIECE_CNT:  pcount_ff <= csr_ch.data[12:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   pbrt_pkg::seq_state_type state_ff, state_in;
   pbrt_pkg::kind_type      kind_ff, kind_in;
   logic [11:0]             idx_ff, idx_in;
   logic [21:0]             off_ff, off_in;
   logic [22:0]             pay_ff, pay_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        b_ff, b_in;
   logic [BM_AW-1:0]        clr_ff, clr_in;
   pbrt_pkg::res_type       res_ff, res_in;
   pbrt_pkg::res_type       out_ff, out_in;
   logic                    out_vld_ff, out_vld_in;

   // slot table
   logic                            slot_valid_ff [SLOTS];
   logic [11:0]                     slot_piece_ff [SLOTS];
   logic [pbrt_pkg::RCV_W-1:0]      slot_cnt_ff   [SLOTS];
   logic [CNT_W-1:0]                slot_tot_ff   [SLOTS];
   logic                            sv_set, sv_clr;
   logic                            slot_open;
   logic                            cnt_wr;
   logic [pbrt_pkg::RCV_W-1:0]      cnt_wdata;
   logic [CNT_W-1:0]                open_tot;

   // RAM and length unit hook-up
   logic                  bm_we, bm_wdata, bm_re, bm_rdata;
   logic [BM_AW-1:0]      bm_waddr, bm_raddr;
   logic                  blk_we, blk_re;
   logic [BA_W-1:0]       blk_waddr, blk_raddr;
   logic [1:0]            blk_wdata, blk_rdata;
   pbrt_pkg::len_req_type len_req;
   logic [LEN_W-1:0]      len;
   logic                  len_done;

   // slot look-up over the table
   logic [SLOTS-1:0]  hit_vec;
   logic              hit_any, free_any;
   logic [SLOT_W-1:0] hit_slot, free_slot;

   always_comb begin
      hit_any   = 1'b0;
      free_any  = 1'b0;
      hit_slot  = '0;
      free_slot = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         hit_vec[s] = slot_valid_ff[s] && (slot_piece_ff[s] == idx_ff);
         if (hit_vec[s]) begin
            hit_any  = 1'b1;
            hit_slot = SLOT_W'(s);
         end
         if (!slot_valid_ff[s]) begin
            free_any  = 1'b1;
            free_slot = SLOT_W'(s);
         end
      end
   end

   // helpers for the current slot and item
   logic [CNT_W-1:0]           cur_tot;
   logic [pbrt_pkg::RCV_W-1:0] cur_cnt, cnt_next;
   logic [7:0]                 off_blk;
   logic                       blk_match, size_ok, in_range;
   logic [SW-1:0]              start, diff;

   always_comb begin
      cur_tot   = slot_tot_ff[slot_ff];
      cur_cnt   = slot_cnt_ff[slot_ff];
      off_blk   = off_ff[21:14];
      blk_match = (off_ff[13:0] == 14'd0) && (11'(off_blk) < 11'(cur_tot))
                  && (11'(off_blk) < 11'(MAX_BLOCKS));
      size_ok   = (CMP_W'(off_ff) + CMP_W'(pay_ff)) <= CMP_W'(len);
      in_range  = (13'(idx_ff) < pcount_ff) && (17'(idx_ff) < 17'(MAX_PIECES));
      start     = SW'(b_ff) << pbrt_pkg::BLOCK_SHIFT;
      diff      = SW'(len) - start;
      cnt_next  = (size_ok && (cur_cnt < pbrt_pkg::RCV_W'(pbrt_pkg::RCV_MAX)))
                  ? cur_cnt + 1'b1 : cur_cnt;
      open_tot  = CNT_W'((SW'(len) + SW'(pbrt_pkg::BLOCK_BYTES - 1)) >>
                         pbrt_pkg::BLOCK_SHIFT);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pbrt_pkg::S_CLR;
         clr_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      idx_ff  <= idx_in;
      off_ff  <= off_in;
      pay_ff  <= pay_in;
      slot_ff <= slot_in;
      b_ff    <= b_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   // next state and controls
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      off_in     = off_ff;
      pay_in     = pay_ff;
      slot_in    = slot_ff;
      b_in       = b_ff;
      clr_in     = clr_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;

      req_ch.ready = 1'b0;
      bm_we     = 1'b0;
      bm_waddr  = clr_ff;
      bm_wdata  = 1'b0;
      bm_re     = 1'b0;
      bm_raddr  = BM_AW'(req_ch.piece_index);
      blk_we    = 1'b0;
      blk_waddr = {slot_ff, b_ff[BLK_W-1:0]};
      blk_wdata = pbrt_pkg::BS_PENDING;
      blk_re    = 1'b0;
      blk_raddr = {slot_ff, b_ff[BLK_W-1:0]};
      len_req.start = 1'b0;
      len_req.idx   = req_ch.piece_index;
      len_req.last  = ((13'(req_ch.piece_index) + 13'd1) == pcount_ff);
      sv_set    = 1'b0;
      sv_clr    = 1'b0;
      slot_open = 1'b0;
      cnt_wr    = 1'b0;
      cnt_wdata = cnt_next;

      if (out_vld_ff && rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         // bitmap clearing pass after reset
         pbrt_pkg::S_CLR: begin
            bm_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BM_AW'(MAX_PIECES - 1)) begin
               state_in = pbrt_pkg::S_IDLE;
            end
         end
         pbrt_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               kind_in = pbrt_pkg::kind_type'(req_ch.kind);
               idx_in  = req_ch.piece_index;
               off_in  = req_ch.block_offset_in;
               pay_in  = req_ch.payload_bytes;
               bm_re   = 1'b1;
               len_req.start = 1'b1;
               state_in = pbrt_pkg::S_LEN;
            end
         end
         pbrt_pkg::S_LEN: begin
            if (len_done) begin
               state_in = pbrt_pkg::S_EXEC;
            end
         end
         // decode the item against bitmap and slot table
         pbrt_pkg::S_EXEC: begin
            res_in = '0;
            res_in.status = pbrt_pkg::ST_NONE;
            res_in.have = bm_rdata;
            b_in = '0;
            state_in = pbrt_pkg::S_DONE;
            if (!in_range) begin
               res_in.status = pbrt_pkg::ST_RANGE;
               res_in.have = 1'b0;
            end else begin
               case (kind_ff)
                  pbrt_pkg::K_NEXT, pbrt_pkg::K_RECEIVED: begin
                     if (!bm_rdata) begin
                        if (hit_any) begin
                           slot_in = hit_slot;
                           state_in = (kind_ff == pbrt_pkg::K_NEXT) ?
                                      pbrt_pkg::S_SCAN : pbrt_pkg::S_MATCH;
                        end else if (!free_any) begin
                           res_in.status = pbrt_pkg::ST_FULL;
                        end else begin
                           slot_in = free_slot;
                           slot_open = 1'b1;
                           state_in = pbrt_pkg::S_WIPE;
                        end
                     end
                  end
                  pbrt_pkg::K_REQ_FAIL: begin
                     if (hit_any) begin
                        slot_in = hit_slot;
                        state_in = pbrt_pkg::S_MATCH;
                     end
                  end
                  pbrt_pkg::K_COMPLETE: begin
                     bm_we = 1'b1;
                     bm_waddr = BM_AW'(idx_ff);
                     bm_wdata = 1'b1;
                     slot_in = hit_slot;
                     sv_clr = hit_any;
                     res_in.status = pbrt_pkg::ST_OK;
                     res_in.have = 1'b1;
                  end
                  pbrt_pkg::K_FAILED: begin
                     if (hit_any) begin
                        slot_in = hit_slot;
                        sv_clr = 1'b1;
                        res_in.status = pbrt_pkg::ST_OK;
                     end
                  end
                  pbrt_pkg::K_QUERY: begin
                     res_in.status = pbrt_pkg::ST_OK;
                     if (!bm_rdata) begin
                        if (hit_any) begin
                           slot_in = hit_slot;
                           state_in = pbrt_pkg::S_SCAN;
                        end else begin
                           res_in.pend = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         // reset block states of a freshly opened slot
         pbrt_pkg::S_WIPE: begin
            if (b_ff < cur_tot) begin
               blk_we = 1'b1;
               b_in = b_ff + 1'b1;
            end else begin
               b_in = '0;
               state_in = (kind_ff == pbrt_pkg::K_NEXT) ?
                          pbrt_pkg::S_SCAN : pbrt_pkg::S_MATCH;
            end
         end
         // look for the first pending block
         pbrt_pkg::S_SCAN: begin
            if (b_ff < cur_tot) begin
               blk_re = 1'b1;
               state_in = pbrt_pkg::S_SCHK;
            end else begin
               state_in = pbrt_pkg::S_DONE;
            end
         end
         pbrt_pkg::S_SCHK: begin
            if (blk_rdata == pbrt_pkg::BS_PENDING) begin
               state_in = pbrt_pkg::S_DONE;
               if (kind_ff == pbrt_pkg::K_NEXT) begin
                  blk_we = 1'b1;
                  blk_wdata = pbrt_pkg::BS_REQUESTED;
                  res_in.status = pbrt_pkg::ST_OK;
                  res_in.found = 1'b1;
                  res_in.boff = 22'(start);
                  if (start < SW'(len)) begin
                     res_in.blen = (diff < SW'(pbrt_pkg::BLOCK_BYTES)) ?
                                   15'(diff) : 15'(pbrt_pkg::BLOCK_BYTES);
                  end
               end else begin
                  res_in.pend = 1'b1;
               end
            end else begin
               b_in = b_ff + 1'b1;
               state_in = pbrt_pkg::S_SCAN;
            end
         end
         // offset to block match for received and request failed
         pbrt_pkg::S_MATCH: begin
            if (blk_match) begin
               b_in = CNT_W'(off_blk);
               blk_re = 1'b1;
               blk_raddr = {slot_ff, BLK_W'(off_blk)};
               state_in = pbrt_pkg::S_MCHK;
            end else begin
               if (kind_ff == pbrt_pkg::K_RECEIVED) begin
                  res_in.full = (11'(cur_cnt) == 11'(cur_tot));
               end
               state_in = pbrt_pkg::S_DONE;
            end
         end
         pbrt_pkg::S_MCHK: begin
            state_in = pbrt_pkg::S_DONE;
            if (kind_ff == pbrt_pkg::K_RECEIVED) begin
               if (blk_rdata != pbrt_pkg::BS_RECEIVED) begin
                  blk_we = 1'b1;
                  blk_wdata = pbrt_pkg::BS_RECEIVED;
                  cnt_wr = 1'b1;
                  res_in.status = pbrt_pkg::ST_OK;
                  res_in.full = (11'(cnt_next) == 11'(cur_tot));
               end else begin
                  res_in.full = (11'(cur_cnt) == 11'(cur_tot));
               end
            end else if (blk_rdata == pbrt_pkg::BS_REQUESTED) begin
               blk_we = 1'b1;
               blk_wdata = pbrt_pkg::BS_PENDING;
               res_in.status = pbrt_pkg::ST_OK;
            end
         end
         // hand the result to the output register
         pbrt_pkg::S_DONE: begin
            if (!out_vld_ff || rsp_ch.ready) begin
               out_in = res_ff;
               out_vld_in = 1'b1;
               state_in = pbrt_pkg::S_IDLE;
            end
         end
         default: state_in = pbrt_pkg::S_IDLE;
      endcase
      sv_set = slot_open;
   end

   // slot table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_valid_ff[s] <= 1'b0;
         end
      end else if (sv_set) begin
         slot_valid_ff[free_slot] <= 1'b1;
      end else if (sv_clr) begin
         slot_valid_ff[hit_slot] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_open) begin
         slot_piece_ff[free_slot] <= idx_ff;
         slot_cnt_ff[free_slot]   <= '0;
         slot_tot_ff[free_slot]   <= open_tot;
      end else if (cnt_wr) begin
         slot_cnt_ff[slot_ff] <= cnt_wdata;
      end
   end

   pbrt_ram #(.W(1), .AW(BM_AW)) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .re    (bm_re),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   pbrt_ram #(.W(2), .AW(BA_W)) u_blk_state (
      .clock (clock),
      .we    (blk_we),
      .waddr (blk_waddr),
      .wdata (blk_wdata),
      .re    (blk_re),
      .raddr (blk_raddr),
      .rdata (blk_rdata)
   );

   pbrt_len_unit #(.MAX_BLOCKS(MAX_BLOCKS), .LEN_W(LEN_W)) u_len (
      .clock      (clock),
      .reset      (reset),
      .req        (len_req),
      .piece_size (psize_ff),
      .file_size  (fsize_ff),
      .len        (len),
      .done       (len_done)
   );

   // response port
   assign rsp_ch.valid            = out_vld_ff;
   assign rsp_ch.status           = out_ff.status;
   assign rsp_ch.block_found      = out_ff.found;
   assign rsp_ch.block_offset_out = out_ff.boff;
   assign rsp_ch.block_length     = out_ff.blen;
   assign rsp_ch.piece_full       = out_ff.full;
   assign rsp_ch.pending_left     = out_ff.pend;
   assign rsp_ch.have_piece       = out_ff.have;

`ifndef SYNTH
   // a piece never holds two slots
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("piece found in more than one slot");

   // a new response only comes out of the result stage
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(state_ff == pbrt_pkg::S_DONE))
      else $error("response raised outside the result stage");

   // the length unit answers only while the sequencer waits for it
   a_len_wait: assert property (@(posedge clock) disable iff (reset)
      len_done |-> (state_ff == pbrt_pkg::S_LEN))
      else $error("length result outside the wait state");
`endif
endmodule

// ----- sim/tb_top.sv -----
// Testbench of the piece block request tracker: directed and random request items
// checked against a behavioural predictor. Depends on pbrt_pkg, pbrt_if, the DUT.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pbrt_pkg::*;

   localparam int NPIECE = 4096;
   localparam int NSLOT  = 8;
   localparam int NBLK   = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count = 0;
   int   src_idle_pct = 23;
   int   snk_idle_pct = 45;

   pbrt_req_if req_ch ();
   pbrt_rsp_if rsp_ch ();
   pbrt_csr_if csr_ch ();

   piece_block_request_tracker uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // tracker predictor with a queue of expected response items
   class tracker_scoreboard;
      logic [22:0] piece_sz;
      logic [34:0] file_sz;
      logic [12:0] n_pieces;
      bit          done_map [NPIECE];
      bit          open     [NSLOT];
      int          owner    [NSLOT];
      int          rcv_cnt  [NSLOT];
      int          blk_tot  [NSLOT];
      blk_state_type blk    [NSLOT][NBLK];
      res_type     pending_q [$];

      function void clear();
         piece_sz = 23'd262144;
         file_sz  = '0;
         n_pieces = '0;
         foreach (done_map[i]) done_map[i] = 1'b0;
         foreach (open[i]) open[i] = 1'b0;
         pending_q.delete();
      endfunction

      function void write_reg(csr_index_type idx, logic [34:0] val);
         case (idx)
            CSR_PIECE_SIZE: piece_sz = val[22:0];
            CSR_FILE_SIZE:  file_sz  = val;
            CSR_PIECE_CNT:  n_pieces = val[12:0];
            default: ;
         endcase
      endfunction

      function longint length_of(int p);
         longint l, prior;
         if (p >= n_pieces) return 0;
         if (p + 1 < n_pieces) l = piece_sz;
         else begin
            prior = longint'(n_pieces - 1) * longint'(piece_sz);
            l = (longint'(file_sz) > prior) ? longint'(file_sz) - prior : 0;
         end
         return (l > NBLK * 16384) ? NBLK * 16384 : l;
      endfunction

      function int slot_of(int p);
         for (int s = 0; s < NSLOT; s++)
            if (open[s] && owner[s] == p) return s;
         return -1;
      endfunction

      function int claim_slot(int p);
         int s;
         s = slot_of(p);
         if (s >= 0) return s;
         for (s = 0; s < NSLOT; s++) if (!open[s]) break;
         if (s >= NSLOT) return -1;
         open[s] = 1'b1;
         owner[s] = p;
         rcv_cnt[s] = 0;
         blk_tot[s] = int'((length_of(p) + 16383) / 16384);
         for (int b = 0; b < NBLK; b++) blk[s][b] = BS_PENDING;
         return s;
      endfunction

      function int block_at(int s, longint off);
         if (off % 16384 != 0) return -1;
         if (off / 16384 >= blk_tot[s]) return -1;
         return int'(off / 16384);
      endfunction

      // work out the response to one accepted request item
      function void note_request(logic [2:0] k, logic [11:0] p, logic [21:0] off,
                                 logic [22:0] pay);
         res_type r;
         int s, b;
         longint len;
         r = '0;
         r.status = ST_NONE;
         if (p >= n_pieces) begin
            r.status = ST_RANGE;
            pending_q = {pending_q, r};
            return;
         end
         case (k)
            K_NEXT: if (!done_map[p]) begin
               s = claim_slot(p);
               if (s < 0) r.status = ST_FULL;
               else for (b = 0; b < blk_tot[s]; b++) if (blk[s][b] == BS_PENDING) begin
                  len = length_of(p);
                  blk[s][b] = BS_REQUESTED;
                  r.status = ST_OK;
                  r.found = 1'b1;
                  r.boff = 22'(b * 16384);
                  if (b * 16384 < len)
                     r.blen = 15'((len - b * 16384 < 16384) ? len - b * 16384 : 16384);
                  break;
               end
            end
            K_RECEIVED: if (!done_map[p]) begin
               s = claim_slot(p);
               if (s < 0) r.status = ST_FULL;
               else begin
                  b = block_at(s, off);
                  if (b >= 0 && blk[s][b] != BS_RECEIVED) begin
                     blk[s][b] = BS_RECEIVED;
                     if (longint'(off) + longint'(pay) <= length_of(p) && rcv_cnt[s] < 511)
                        rcv_cnt[s]++;
                     r.status = ST_OK;
                  end
                  r.full = (rcv_cnt[s] == blk_tot[s]);
               end
            end
            K_REQ_FAIL: begin
               s = slot_of(p);
               if (s >= 0) begin
                  b = block_at(s, off);
                  if (b >= 0 && blk[s][b] == BS_REQUESTED) begin
                     blk[s][b] = BS_PENDING;
                     r.status = ST_OK;
                  end
               end
            end
            K_COMPLETE: begin
               done_map[p] = 1'b1;
               s = slot_of(p);
               if (s >= 0) open[s] = 1'b0;
               r.status = ST_OK;
            end
            K_FAILED: begin
               s = slot_of(p);
               if (s >= 0) begin
                  open[s] = 1'b0;
                  r.status = ST_OK;
               end
            end
            K_QUERY: begin
               r.status = ST_OK;
               if (!done_map[p]) begin
                  s = slot_of(p);
                  if (s < 0) r.pend = 1'b1;
                  else for (b = 0; b < blk_tot[s]; b++)
                     if (blk[s][b] == BS_PENDING) begin
                        r.pend = 1'b1;
                        break;
                     end
               end
            end
            default: ;
         endcase
         r.have = done_map[p];
         pending_q = {pending_q, r};
      endfunction

      task check_response(res_type got);
         res_type e;
         if (pending_q.size() == 0) begin
            report_mismatch("response item with nothing expected");
            return;
         end
         e = pending_q.pop_front();
         if (got.status != e.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
         if (got.found != e.found)
            report_mismatch($sformatf("block_found %0d, want %0d", got.found, e.found));
         if (got.boff != e.boff)
            report_mismatch($sformatf("block_offset_out %0d, want %0d", got.boff, e.boff));
         if (got.blen != e.blen)
            report_mismatch($sformatf("block_length %0d, want %0d", got.blen, e.blen));
         if (got.full != e.full)
            report_mismatch($sformatf("piece_full %0d, want %0d", got.full, e.full));
         if (got.pend != e.pend)
            report_mismatch($sformatf("pending_left %0d, want %0d", got.pend, e.pend));
         if (got.have != e.have)
            report_mismatch($sformatf("have_piece %0d, want %0d", got.have, e.have));
      endtask
   endclass

   tracker_scoreboard sb = new();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.piece_index = '0;
      req_ch.block_offset_in = '0;
      req_ch.payload_bytes = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // response side: random back-pressure, sampled at the rising edge
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response('{status: status_type'(rsp_ch.status),
                             found: rsp_ch.block_found, boff: rsp_ch.block_offset_out,
                             blen: rsp_ch.block_length, full: rsp_ch.piece_full,
                             pend: rsp_ch.pending_left, have: rsp_ch.have_piece});

   task automatic write_csr(csr_index_type idx, logic [34:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_request(logic [2:0] k, logic [11:0] p, logic [21:0] off,
                               logic [22:0] pay);
      do @(negedge clock); while ($urandom_range(99) < src_idle_pct);
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.piece_index <= p;
      req_ch.block_offset_in <= off;
      req_ch.payload_bytes <= pay;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(k, p, off, pay);
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // wait for outstanding responses, then let the block settle
   task automatic drain();
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (3 * NBLK + 20) @(negedge clock);
   endtask

   task automatic set_geometry(logic [22:0] psz, logic [34:0] fsz, logic [12:0] cnt);
      write_csr(CSR_PIECE_SIZE, psz);
      write_csr(CSR_FILE_SIZE, fsz);
      write_csr(CSR_PIECE_CNT, cnt);
   endtask

   // random item mostly aimed at a few open pieces with block-aligned offsets
   task automatic random_request(int focus);
      logic [2:0] k;
      logic [11:0] p;
      logic [21:0] off;
      logic [22:0] pay;
      int r;
      r = $urandom_range(99);
      if (r < 40) k = K_NEXT;
      else if (r < 70) k = K_RECEIVED;
      else if (r < 80) k = K_REQ_FAIL;
      else if (r < 86) k = K_COMPLETE;
      else if (r < 91) k = K_FAILED;
      else if (r < 98) k = K_QUERY;
      else k = 3'($urandom_range(7));
      if ($urandom_range(19) == 0) p = 12'($urandom);
      else p = 12'($urandom_range(focus));
      if ($urandom_range(9) == 0) off = 22'($urandom);
      else off = 22'($urandom_range(15) * 16384);
      if ($urandom_range(9) == 0) pay = 23'($urandom);
      else pay = 23'(16384 - $urandom_range(1) * $urandom_range(16384));
      send_request(k, p, off, pay);
   endtask

   initial begin
      sb.clear();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: tiny geometry with short last piece
      set_geometry(23'd40000, 35'd100000, 13'd3);
      send_request(K_QUERY, 12'd0, '0, '0);
      send_request(K_NEXT, 12'd2, '0, '0);
      send_request(K_NEXT, 12'd2, '0, '0);
      send_request(K_NEXT, 12'd2, '0, '0);
      send_request(K_REQ_FAIL, 12'd2, '0, '0);
      send_request(K_REQ_FAIL, 12'd2, 22'd100, '0);
      send_request(K_RECEIVED, 12'd2, '0, 23'd16384);
      send_request(K_RECEIVED, 12'd2, 22'd16384, 23'h7FFFFF);
      send_request(K_RECEIVED, 12'd2, '0, 23'd16384);
      send_request(K_QUERY, 12'd2, '0, '0);
      send_request(K_FAILED, 12'd2, '0, '0);
      send_request(K_FAILED, 12'd2, '0, '0);
      send_request(K_COMPLETE, 12'd1, '0, '0);
      send_request(K_NEXT, 12'd1, '0, '0);
      send_request(K_RECEIVED, 12'd1, '0, '0);
      send_request(K_QUERY, 12'd1, '0, '0);
      send_request(3'd6, 12'd0, '0, '0);
      send_request(3'd7, 12'd0, 22'h3FFFFF, 23'h7FFFFF);
      send_request(K_NEXT, 12'd3, '0, '0);
      send_request(K_NEXT, 12'hFFF, '0, '0);
      // fill the table, then overflow it
      for (int i = 0; i < 3; i++) send_request(K_NEXT, 12'(i), '0, '0);
      drain();
      set_geometry(23'd16384, 35'd16384 * 20, 13'd20);
      for (int i = 3; i < 12; i++) send_request(K_RECEIVED, 12'(i), '0, 23'd16384);
      drain();

      // zero-length last piece and maximum sizes
      set_geometry(23'd4194304, 35'd100, 13'd2);
      send_request(K_NEXT, 12'd1, '0, '0);
      send_request(K_RECEIVED, 12'd1, '0, '0);
      send_request(K_NEXT, 12'd0, '0, '0);
      drain();

      // random phases over several geometries, small pieces mostly
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin src_idle_pct = 23; snk_idle_pct = 45; end
            2: begin src_idle_pct = 45; snk_idle_pct = 23; end
            4: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            default: ;
         endcase
         case (ph)
            0: set_geometry(23'd65536, 35'd65536 * 11 + 5000, 13'd12);
            1: set_geometry(23'd50000, 35'd50000 * 9, 13'd10);
            2: set_geometry(23'd16384, 35'd16384 * 15 + 1, 13'd16);
            3: set_geometry(23'd131072, 35'h7FFFFFFFF, 13'd4096);
            4: set_geometry(23'd98304, 35'd98304 * 5 - 16384, 13'd6);
            default: set_geometry(23'd4194304, 35'd4194304 + 20000, 13'd2);
         endcase
         for (int i = 0; i < 280; i++) begin
            random_request(ph == 3 ? 15 : 13);
            if (i == 140) begin
               while (sb.pending_q.size() != 0) @(negedge clock);
            end
         end
         drain();
         // after phase 1, move the registers under open slots
         if (ph == 1) set_geometry(23'd30000, 35'd30000 * 9, 13'd10);
         if (ph == 1) begin
            for (int i = 0; i < 40; i++) random_request(11);
            drain();
         end
      end

      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #40ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/pbrt_pkg.sv
rtl/pbrt_if.sv
rtl/pbrt_ram.sv
rtl/pbrt_len_unit.sv
rtl/piece_block_request_tracker.sv
sim/tb_top.sv
